FILE: design/pressure_altitude_taylor_core_defines.svh
// Assertion macros shared by the pressure altitude core.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef PRESSURE_ALTITUDE_TAYLOR_CORE_DEFINES_SVH
`define PRESSURE_ALTITUDE_TAYLOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pat_pkg.sv
// Shared types and constants for the pressure altitude core.
// No dependencies.
`timescale 1ns / 1ps

package pat_pkg;

    // Width of the pressure fraction and of the quotient.
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 32;
    localparam int PRESS_W    = 17;
    // Reciprocal precision for division by a small constant.
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_BASE_PRESSURE = 2'd0,
        REG_INV_EXP_SCALE = 2'd1,
        REG_ALT_SCALE     = 2'd2
    } t_reg_idx;

    // Data moving through the divider cells.
    typedef struct packed {
        logic              nbb;
        logic              zero;
        logic [FRAC_W-1:0] rem;
        logic [FRAC_W-1:0] den;
        logic [FRAC_W-1:0] quo;
    } t_div_data;

    // Data moving through the series cells.
    typedef struct packed {
        logic              nbb;
        logic [FRAC_W-1:0] x;
        logic [FRAC_W-1:0] pw;
        logic [ACC_W-1:0]  acc;
    } t_ser_data;

    // n! for small n.
    function automatic int factorial(input int n);
        int f;
        f = 1;
        for (int k = 2; k <= n; k++) begin
            f = f * k;
        end
        return f;
    endfunction

endpackage

FILE: design/pressure_altitude_taylor_core.sv
// Barometric altitude core: one pressure beat in, one altitude beat out, one item per cycle
// sustained while i_out_ready does not stall the output, through this chain of cells:
// an entry stage, sixteen divider cells (one quotient bit each), LOG_TERMS log-series cells,
// an exponent-scaling stage, EXP_TERMS-1 exp-series cells and the output register. Each
// stage holds its beat until the next frees up, so bubbles collapse and the input keeps flowing
// while a result waits, until all are full. Configuration writes are expected only when idle.
`timescale 1ns / 1ps

module pressure_altitude_taylor_core #(
    parameter int LOG_TERMS = 14,
    parameter int EXP_TERMS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [16:0] i_pressure,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_altitude,
    output logic        o_not_below_base
);
    import pat_pkg::*;
`include "pressure_altitude_taylor_core_defines.svh"

    localparam int DIV_BASE = 1;
    localparam int LOG_BASE = DIV_BASE + FRAC_W;
    localparam int Y_IDX    = LOG_BASE + LOG_TERMS;
    localparam int EXP_BASE = Y_IDX;
    localparam int OUT_IDX  = Y_IDX + EXP_TERMS;
    localparam int NS       = OUT_IDX + 1;

    // Configuration registers.
    logic [PRESS_W-1:0] r_base;
    logic [FRAC_W-1:0]  r_inv;
    logic [FRAC_W-1:0]  r_asc;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= PRESS_W'(101325);
            r_inv  <= FRAC_W'(12469);
            r_asc  <= FRAC_W'(44330);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_BASE_PRESSURE: r_base <= pwdata[PRESS_W-1:0];
                REG_INV_EXP_SCALE: r_inv  <= pwdata[FRAC_W-1:0];
                REG_ALT_SCALE:     r_asc  <= pwdata[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_idx)
            REG_BASE_PRESSURE: prdata = 32'(r_base);
            REG_INV_EXP_SCALE: prdata = 32'(r_inv);
            REG_ALT_SCALE:     prdata = 32'(r_asc);
            default:           prdata = 32'd0;
        endcase
    end

    // Per-stage valid bits and the advance chain from the output backwards.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_mv;

    always_comb begin
        w_mv[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_mv[k] = !r_vld[k] || w_mv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_mv[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_in_ready  = w_mv[0];
    assign o_out_valid = r_vld[NS-1];

    // Entry stage: compare against the base and set up the division.
    t_div_data w_div [0:FRAC_W];
    t_div_data n_s0;
    t_div_data r_s0;

    always_comb begin
        n_s0.nbb  = (i_pressure >= r_base);
        n_s0.rem  = i_pressure[PRESS_W-1:1];
        n_s0.den  = r_base[PRESS_W-1:1];
        n_s0.zero = (n_s0.rem == n_s0.den) || (n_s0.den == '0);
        n_s0.quo  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[0]) begin
            r_s0 <= n_s0;
        end
    end

    assign w_div[0] = r_s0;

    // Divider cells.
    for (genvar g = 0; g < FRAC_W; g++) begin : g_div
        pat_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_mv[DIV_BASE+g]),
            .i_d   (w_div[g]),
            .o_d   (w_div[g+1])
        );
    end

    // Log series cells: sum of x^i / i.
    t_ser_data w_log [0:LOG_TERMS];
    logic [FRAC_W-1:0] w_x;

    assign w_x = w_div[FRAC_W].zero ? '0 : FRAC_W'(-w_div[FRAC_W].quo);
    assign w_log[0] = '{nbb: w_div[FRAC_W].nbb, x: w_x, pw: w_x, acc: '0};

    for (genvar g = 0; g < LOG_TERMS; g++) begin : g_log
        pat_series_cell #(.DIVISOR(g + 1), .SUB(1'b0)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_mv[LOG_BASE+g]),
            .i_d   (w_log[g]),
            .o_d   (w_log[g+1])
        );
    end

    // Exponent scaling: y = (l * inv_exponent_scale) >> 16.
    t_ser_data w_exp [0:EXP_TERMS-1];
    t_ser_data r_y;
    logic [ACC_W+FRAC_W-1:0] w_yprod;

    assign w_yprod = w_log[LOG_TERMS].acc * r_inv;

    always_ff @(posedge i_clk) begin
        if (w_mv[Y_IDX]) begin
            r_y.nbb <= w_log[LOG_TERMS].nbb;
            r_y.x   <= w_yprod[FRAC_W +: FRAC_W];
            r_y.pw  <= w_yprod[FRAC_W +: FRAC_W];
            r_y.acc <= '0;
        end
    end

    assign w_exp[0] = r_y;

    // Exp series cells: alternating terms y^i / i!.
    for (genvar g = 1; g < EXP_TERMS; g++) begin : g_exp
        pat_series_cell #(.DIVISOR(factorial(g)), .SUB((g % 2) == 1)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_mv[EXP_BASE+g]),
            .i_d   (w_exp[g-1]),
            .o_d   (w_exp[g])
        );
    end

    // Output stage: scale the fraction to metres.
    logic [FRAC_W-1:0]   w_frac;
    logic [2*FRAC_W-1:0] w_aprod;
    logic [FRAC_W-1:0]   r_alt;
    logic                r_nbb;

    assign w_frac  = FRAC_W'(-w_exp[EXP_TERMS-1].acc[FRAC_W-1:0]);
    assign w_aprod = w_frac * r_asc;

    always_ff @(posedge i_clk) begin
        if (w_mv[OUT_IDX]) begin
            r_nbb <= w_exp[EXP_TERMS-1].nbb;
            r_alt <= w_exp[EXP_TERMS-1].nbb ? '0 : w_aprod[2*FRAC_W-1:FRAC_W];
        end
    end

    assign o_altitude       = r_alt;
    assign o_not_below_base = r_nbb;

    // Checks on the pipeline control and the result.
    `PAT_ASSERT_IMP(a_flag_zero, o_out_valid && o_not_below_base, o_altitude == '0, "bad flag")
    `PAT_ASSERT_IMP(a_empty_ready, !o_out_valid, o_in_ready, "input stalled with empty output")
    `PAT_ASSERT_NXT(a_entry_fill, i_in_valid && o_in_ready, r_vld[0], "beat lost at entry")

endmodule

FILE: design/pat_div_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
// Depends on pat_pkg.
`timescale 1ns / 1ps

module pat_div_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  pat_pkg::t_div_data i_d,
    output pat_pkg::t_div_data o_d
);
    import pat_pkg::*;

    logic [FRAC_W:0] w_shift;
    logic [FRAC_W:0] w_diff;
    logic            w_bit;
    t_div_data       n_d;
    t_div_data       r_d;

    // Shift the remainder and try a subtraction of the divisor.
    always_comb begin
        w_shift = {i_d.rem, 1'b0};
        w_diff  = w_shift - {1'b0, i_d.den};
        w_bit   = (w_shift >= {1'b0, i_d.den});
        n_d      = i_d;
        n_d.rem  = w_bit ? w_diff[FRAC_W-1:0] : w_shift[FRAC_W-1:0];
        n_d.quo  = {i_d.quo[FRAC_W-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: design/pat_series_cell.sv
// One power-series cell: adds or subtracts power/DIVISOR and forms the next power.
// Depends on pat_pkg.
`timescale 1ns / 1ps

module pat_series_cell #(
    parameter int DIVISOR = 1,
    parameter bit SUB     = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  pat_pkg::t_ser_data i_d,
    output pat_pkg::t_ser_data o_d
);
    import pat_pkg::*;

    // Rounded-up reciprocal; exact quotient for 16-bit powers and DIVISOR below 8192.
    localparam logic [RECIP_W-1:0] RECIP = (DIVISOR == 1) ?
        RECIP_W'(64'd1 << RECIP_SHIFT) : RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR + 1);

    logic [FRAC_W+RECIP_W-1:0] w_qprod;
    logic [2*FRAC_W-1:0]       w_pprod;
    logic [ACC_W-1:0]          w_term;
    t_ser_data                 n_d;
    t_ser_data                 r_d;

    // Term division by reciprocal, accumulation, and next power.
    always_comb begin
        w_qprod = FRAC_W'(i_d.pw) * RECIP;
        w_pprod = i_d.pw * i_d.x;
        w_term  = ACC_W'(w_qprod[RECIP_SHIFT +: FRAC_W]);
        n_d     = i_d;
        n_d.pw  = w_pprod[2*FRAC_W-1:FRAC_W];
        n_d.acc = SUB ? (i_d.acc - w_term) : (i_d.acc + w_term);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: tb/altitude_checker.sv
// Checker for the pressure altitude core: watches both channels, predicts each altitude beat
// and compares it with the block's output. Depends on pat_pkg for register indexes.
`timescale 1ns / 1ps

module altitude_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [16:0] i_pressure,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_altitude,
    input  logic        i_not_below_base,
    output int          o_errors,
    output int          o_pending
);
    import pat_pkg::*;

    localparam int LOG_N = 14;
    localparam int EXP_N = 4;

    typedef struct packed {
        logic [15:0] altitude;
        logic        nbb;
    } t_alt_result;

    logic [16:0] base_p;
    logic [15:0] inv_k;
    logic [15:0] alt_scale;
    t_alt_result altitudes_due[$];

    function automatic logic [15:0] fmul(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] prod;
        prod = a * b;
        return prod[31:16];
    endfunction

    // Fixed-point altitude below the base pressure, log series then exp series.
    function automatic logic [15:0] altitude_below(input logic [16:0] p, input logic [16:0] p0);
        logic [15:0] num, den, ratio, x, pw, y, ev, q, fact, term;
        logic [31:0] l, quo;
        logic [63:0] prod;
        num = p[16:1];
        den = p0[16:1];
        ratio = '0;
        if (den != 0) begin
            quo = {num, 16'h0} / den;
            ratio = quo[15:0];
        end
        x = -ratio;
        pw = x;
        l = '0;
        for (int i = 0; i < LOG_N; i++) begin
            l = l + 32'(pw) / (i + 1);
            pw = fmul(pw, x);
        end
        prod = 64'(l) * 64'(inv_k);
        y = prod[31:16];
        ev = y;
        q = '0;
        fact = 16'd1;
        for (int i = 1; i < EXP_N; i++) begin
            fact = fact * 16'(i);
            term = (fact != 0) ? ev / fact : 16'd0;
            ev = fmul(ev, y);
            if (i % 2 == 0) begin
                q = q + term;
            end else begin
                q = q - term;
            end
        end
        return fmul(-q, alt_scale);
    endfunction

    assign o_pending = altitudes_due.size();

    always @(posedge i_clk) begin
        t_alt_result want;
        if (!i_rst_n) begin
            base_p <= 17'd101325;
            inv_k <= 16'd12469;
            alt_scale <= 16'd44330;
            altitudes_due.delete();
            o_errors <= 0;
        end else begin
            // Register writes mirror the block's configuration.
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_BASE_PRESSURE: base_p <= pwdata[16:0];
                    REG_INV_EXP_SCALE: inv_k <= pwdata[15:0];
                    REG_ALT_SCALE:     alt_scale <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_pressure >= base_p) begin
                    want = '{altitude: 16'd0, nbb: 1'b1};
                end else begin
                    want = '{altitude: altitude_below(i_pressure, base_p), nbb: 1'b0};
                end
                altitudes_due.push_back(want);
            end
            // Output beats are compared with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (altitudes_due.size() == 0) begin
                    $display("%0t: unexpected beat altitude %0d flag %0b", $time,
                             i_altitude, i_not_below_base);
                    o_errors <= o_errors + 1;
                end else begin
                    want = altitudes_due.pop_front();
                    if (want.altitude !== i_altitude || want.nbb !== i_not_below_base) begin
                        $display("%0t: expected altitude %0d flag %0b, got %0d flag %0b",
                                 $time, want.altitude, want.nbb, i_altitude,
                                 i_not_below_base);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/testbench.sv
// Top of the pressure altitude testbench: clock, reset, APB writes and pressure stimulus.
// Depends on pat_pkg, the core and altitude_checker.
`timescale 1ns / 1ps

module testbench;
    import pat_pkg::*;

    localparam int LATENCY = 18 + 14 + 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [16:0] pressure = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] altitude;
    logic        not_below_base;
    int          errors, pending;
    logic [16:0] base_now = 17'd101325;
    bit          drain_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pressure_altitude_taylor_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_pressure(pressure),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_altitude(altitude), .o_not_below_base(not_below_base)
    );

    altitude_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_pressure(pressure),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_altitude(altitude), .i_not_below_base(not_below_base),
        .o_errors(errors), .o_pending(pending)
    );

    // Setup then access cycle on the configuration port.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_BASE_PRESSURE) begin
            base_now = value[16:0];
        end
    endtask

    // One pressure beat after a random gap; valid stays high until accepted.
    task automatic send_pressure(input logic [16:0] p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        pressure <= p;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Mostly below the base, with some at the base, some one off it and some anywhere in the range.
    function automatic logic [16:0] random_pressure();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6 && base_now > 0) return 17'($urandom_range(0, base_now - 1));
        if (pick == 6) return base_now;
        if (pick == 7) return base_now ^ 17'd1;
        return 17'($urandom);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count);
        for (int n = 0; n < count; n++) begin
            send_pressure(random_pressure());
        end
        drain();
    endtask

    // Receiver stalls drawn per beat.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: range ends, equality, wrap cases, reset settings.
        send_pressure(17'd0);
        send_pressure(17'd1);
        send_pressure(17'h1FFFF);
        send_pressure(17'd101325);
        send_pressure(17'd101324);
        send_pressure(17'd101326);
        send_pressure(17'd50000);
        send_pressure(17'd89875);
        send_pressure(17'h15555);
        send_pressure(17'h0AAAA);
        drain();
        // Extreme settings, including the smallest base that gives a nonzero divisor.
        write_reg(REG_BASE_PRESSURE, 32'd2);
        write_reg(REG_INV_EXP_SCALE, 32'd65535);
        write_reg(REG_ALT_SCALE, 32'd65535);
        send_pressure(17'd0);
        send_pressure(17'd1);
        send_pressure(17'd2);
        drain();
        write_reg(REG_BASE_PRESSURE, 32'h1FFFF);
        write_reg(REG_INV_EXP_SCALE, 32'd1);
        write_reg(REG_ALT_SCALE, 32'd1);
        send_pressure(17'd0);
        send_pressure(17'h1FFFE);
        send_pressure(17'h1FFFF);
        send_pressure(17'd3);
        run_phase(60);
        write_reg(REG_BASE_PRESSURE, 32'h1FFFF);
        write_reg(REG_INV_EXP_SCALE, 32'd65535);
        write_reg(REG_ALT_SCALE, 32'd65535);
        run_phase(100);
        write_reg(REG_BASE_PRESSURE, 32'd101325);
        write_reg(REG_INV_EXP_SCALE, 32'd12469);
        write_reg(REG_ALT_SCALE, 32'd44330);
        run_phase(140);
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_BASE_PRESSURE, $urandom_range(2, 131071));
            write_reg(REG_INV_EXP_SCALE, $urandom_range(1, 65535));
            write_reg(REG_ALT_SCALE, $urandom_range(1, 65535));
            run_phase(50);
        end
        drain_done = 1'b1;
    end

    // Verdict once everything has drained.
    initial begin
        wait (drain_done);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
